/* hdl/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg: shared definitions of the buddy block allocator
// Widths, codes and order clamping helpers used by the core and its store.
// ----------------------------------------------------------------------------
package bba_pkg;

	// Defaults of the top level parameters.
	localparam int MAX_LEVELS_D   = 12;
	localparam int HEADER_BYTES_D = 16;

	// Fixed field widths.
	localparam int ORD_W  = 5;
	localparam int TAG_W  = ORD_W + 1;
	localparam int ADDR_W = 20;
	localparam int LEN_W  = 32;
	localparam int NEED_W = LEN_W + 1;
	localparam int ORD_LIMIT = 20;

	// Reset values of the configuration registers.
	localparam logic [ORD_W-1:0] MIN_ORDER_RST   = 5'd7;
	localparam logic [ORD_W-1:0] ARENA_ORDER_RST = 5'd19;

	// Result status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BIG    = 2'd1;
	localparam logic [1:0] ST_NOFREE = 2'd2;

	// Request kinds.
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_MIN_ORDER   = 1'b0;
	localparam logic CFG_ARENA_ORDER = 1'b1;

	// Write strobes from the sequencer to the block store.
	typedef struct packed {
		logic tag_we;
		logic link_we;
		logic clear;
	} store_ctl_t;

	// Effective minimum order: limited to the largest offset width.
	function automatic logic [ORD_W-1:0] eff_min_f(input logic [ORD_W-1:0] m);
		logic [ORD_W-1:0] r;
		r = m;
		if (r > ORD_W'(ORD_LIMIT)) r = ORD_W'(ORD_LIMIT);
		return r;
	endfunction

	// Effective arena order: clamped between the minimum order and the top.
	function automatic logic [ORD_W-1:0] eff_arena_f(input logic [ORD_W-1:0] m,
			input logic [ORD_W-1:0] a, input int max_levels);
		int mm;
		int top;
		int aa;
		mm = int'(eff_min_f(m));
		top = mm + max_levels;
		if (top > ORD_LIMIT) top = ORD_LIMIT;
		aa = int'(a);
		if (aa < mm) aa = mm;
		if (aa > top) aa = top;
		return ORD_W'(aa);
	endfunction

endpackage

/* hdl/buddy_block_allocator_core.sv */
// ----------------------------------------------------------------------------
// buddy_block_allocator_core: binary buddy allocator over an offset arena
// Allocates and frees power-of-two blocks under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive as beats on the s_ group: s_tuser is the kind (0 allocate,
//   1 free), s_tdata carries the length and the address to release. Each
//   request yields exactly one result beat on the m_ group with the granted
//   user offset and a status.
//   Configuration beats on the cfg_ channel set the minimum and arena orders;
//   either write reinitialises the arena to one free block.
//   The shortest request is a free of an address that cannot name a block;
//   sizing walks one order a cycle, and every split or merge costs a list
//   unlink through the link memory, whose walk passes each list entry through
//   the S_UWLK and S_UDAT states. One request is in work at a time.
//   After reset and after every configuration write, a clearing pass rewrites
//   all 2^MAX_LEVELS block tags; s_tready stays low meanwhile.
//   A finished result waits in the output register while m_tready is low; the
//   next request may be accepted then, but its result waits for that beat.
// ----------------------------------------------------------------------------
module buddy_block_allocator_core import bba_pkg::*; #(
	parameter int MAX_LEVELS   = MAX_LEVELS_D,
	parameter int HEADER_BYTES = HEADER_BYTES_D
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,    // length [31:0], address [51:32], zero pad
	input  logic        s_tuser,    // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,    // address_out [19:0], status [21:20], zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data
);

	localparam int IW   = MAX_LEVELS;
	localparam int NBLK = 1 << IW;
	localparam int NLV  = MAX_LEVELS + 1;
	localparam int LW   = $clog2(NLV);

	// Sequencer states.
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_ASIZ = 5'd1;
	localparam logic [4:0] S_AFND = 5'd2;
	localparam logic [4:0] S_ASPL = 5'd3;
	localparam logic [4:0] S_ACUT = 5'd4;
	localparam logic [4:0] S_AUPP = 5'd5;
	localparam logic [4:0] S_APSH = 5'd6;
	localparam logic [4:0] S_AGNT = 5'd7;
	localparam logic [4:0] S_FCHK = 5'd8;
	localparam logic [4:0] S_FTAG = 5'd9;
	localparam logic [4:0] S_FBUD = 5'd10;
	localparam logic [4:0] S_FCMP = 5'd11;
	localparam logic [4:0] S_FUL2 = 5'd12;
	localparam logic [4:0] S_FMRG = 5'd13;
	localparam logic [4:0] S_UHD0 = 5'd14;
	localparam logic [4:0] S_UHED = 5'd15;
	localparam logic [4:0] S_UWLK = 5'd16;
	localparam logic [4:0] S_UDAT = 5'd17;
	localparam logic [4:0] S_UFIX = 5'd18;
	localparam logic [4:0] S_DONE = 5'd19;

	logic [4:0]        state_q;
	logic [4:0]        ret_q;
	logic [ORD_W-1:0]  cfg_min_q;
	logic [ORD_W-1:0]  cfg_arena_q;
	logic [ORD_W-1:0]  eff_min_q;
	logic [ORD_W-1:0]  eff_arena_q;
	logic [NEED_W-1:0] need_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ORD_W-1:0]  o_q;
	logic [ORD_W-1:0]  ord_q;
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     bud_q;
	logic [IW-1:0]     up_q;
	logic [IW-1:0]     u_idx_q;
	logic [LW-1:0]     u_lv_q;
	logic [IW:0]       u_cur_q;
	logic [IW:0]       u_steps_q;
	logic [IW:0]       heads_q [NLV];
	logic [ADDR_W-1:0] res_addr_q;
	logic [1:0]        res_status_q;
	logic              m_valid_q;
	logic [23:0]       m_data_q;

	logic              busy;
	logic              in_acc;
	logic              cfg_acc;
	logic [ORD_W-1:0]  new_min;
	logic [ORD_W-1:0]  new_arena;
	store_ctl_t        ctl;
	logic [IW-1:0]     tag_raddr;
	logic [TAG_W-1:0]  tag_rdata;
	logic [IW-1:0]     tag_waddr;
	logic [TAG_W-1:0]  tag_wdata;
	logic [IW-1:0]     link_raddr;
	logic [IW:0]       link_rdata;
	logic [IW-1:0]     link_waddr;
	logic [IW:0]       link_wdata;
	logic              push_en;
	logic [IW-1:0]     push_idx;
	logic [ORD_W-1:0]  push_ord;
	logic [LW-1:0]     push_lv;
	logic              hw_en;
	logic [LW-1:0]     hw_lv;
	logic [IW:0]       hw_val;
	logic [IW:0]       half_sz;
	logic [ADDR_W-1:0] f_off;
	logic [ADDR_W:0]   f_mask;
	logic [IW-1:0]     f_idx;
	logic [IW-1:0]     merge_idx;
	logic [IW:0]       heads_lv;
	logic [39:0]       grant_off;

	assign in_acc    = s_tvalid && s_tready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign s_tready  = (state_q == S_IDLE) && !busy;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;

	// New register values of a configuration beat.
	assign new_min   = (cfg_index == CFG_MIN_ORDER) ? cfg_data : cfg_min_q;
	assign new_arena = (cfg_index == CFG_ARENA_ORDER) ? cfg_data : cfg_arena_q;

	// Shared shift unit: the size of a block of order ord_q in minimum blocks.
	assign half_sz   = (IW + 1)'(1) << (ord_q - eff_min_q);
	assign heads_lv  = heads_q[LW'(eff_arena_q - ord_q)];
	assign merge_idx = (bud_q < idx_q) ? bud_q : idx_q;
	assign grant_off = (40'(idx_q) << eff_min_q) + 40'(HEADER_BYTES);

	// Free request address decode.
	assign f_off  = addr_q - ADDR_W'(HEADER_BYTES);
	assign f_mask = ((ADDR_W + 1)'(1) << eff_min_q) - 1'b1;
	assign f_idx  = IW'(f_off >> eff_min_q);

	// Memory ports and list head writes for the current step.
	always_comb begin
		ctl        = '0;
		ctl.clear  = cfg_acc;
		tag_raddr  = idx_q;
		tag_waddr  = idx_q;
		tag_wdata  = {1'b1, ord_q};
		link_raddr = u_idx_q;
		push_en    = 1'b0;
		push_idx   = idx_q;
		push_ord   = ord_q;
		hw_en      = 1'b0;
		hw_lv      = u_lv_q;
		hw_val     = link_rdata;
		link_waddr = u_cur_q[IW-1:0];
		link_wdata = link_rdata;
		unique case (state_q)
			S_ACUT: begin
				ctl.tag_we = 1'b1;
				tag_wdata  = {1'b1, ord_q - 1'b1};
			end
			S_AUPP: begin
				ctl.tag_we = 1'b1;
				tag_waddr  = idx_q + half_sz[IW-1:0];
				push_en    = 1'b1;
			end
			S_APSH: begin
				push_en  = 1'b1;
				push_idx = up_q;
			end
			S_AGNT: begin
				ctl.tag_we = 1'b1;
				tag_wdata  = {1'b0, o_q};
			end
			S_FCHK: tag_raddr = f_idx;
			S_FTAG: begin
				push_ord = tag_rdata[ORD_W-1:0];
				if (!tag_rdata[ORD_W] && (push_ord >= eff_min_q) && (push_ord <= eff_arena_q)) begin
					ctl.tag_we = 1'b1;
					tag_wdata  = {1'b1, push_ord};
					push_en    = 1'b1;
				end
			end
			S_FBUD: tag_raddr = idx_q ^ half_sz[IW-1:0];
			S_FMRG: begin
				ctl.tag_we = 1'b1;
				tag_waddr  = merge_idx;
				tag_wdata  = {1'b1, ord_q + 1'b1};
				push_en    = 1'b1;
				push_idx   = merge_idx;
				push_ord   = ord_q + 1'b1;
			end
			S_UHED: hw_en = 1'b1;
			S_UWLK: link_raddr = u_cur_q[IW-1:0];
			S_UFIX: ctl.link_we = 1'b1;
			default: ;
		endcase
		push_lv = LW'(eff_arena_q - push_ord);
		if (push_en) begin
			ctl.link_we = 1'b1;
			link_waddr  = push_idx;
			link_wdata  = heads_q[push_lv];
			hw_en       = 1'b1;
			hw_lv       = push_lv;
			hw_val      = {1'b1, push_idx};
		end
	end

	// List heads: the top list holds block zero after (re)initialisation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NLV; i++) heads_q[i] <= '0;
			heads_q[0] <= {1'b1, {IW{1'b0}}};
		end else if (cfg_acc) begin
			for (int i = 0; i < NLV; i++) heads_q[i] <= '0;
			heads_q[0] <= {1'b1, {IW{1'b0}}};
		end else if (hw_en) begin
			heads_q[hw_lv] <= hw_val;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_min_q   <= MIN_ORDER_RST;
			cfg_arena_q <= ARENA_ORDER_RST;
			eff_min_q   <= eff_min_f(MIN_ORDER_RST);
			eff_arena_q <= eff_arena_f(MIN_ORDER_RST, ARENA_ORDER_RST, MAX_LEVELS);
		end else if (cfg_acc) begin
			cfg_min_q   <= new_min;
			cfg_arena_q <= new_arena;
			eff_min_q   <= eff_min_f(new_min);
			eff_arena_q <= eff_arena_f(new_min, new_arena, MAX_LEVELS);
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ret_q     <= S_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_tready && (state_q != S_DONE)) m_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_acc) begin
					need_q       <= NEED_W'(s_tdata[31:0]) + NEED_W'(HEADER_BYTES);
					addr_q       <= s_tdata[51:32];
					o_q          <= eff_min_q;
					res_addr_q   <= '0;
					res_status_q <= ST_OK;
					state_q      <= (s_tuser == KIND_FREE) ? S_FCHK : S_ASIZ;
				end
				// Size search: one order a cycle through the comparator.
				S_ASIZ: begin
					if (o_q > eff_arena_q) begin
						res_status_q <= ST_BIG;
						state_q      <= S_DONE;
					end else if (need_q <= (NEED_W'(1) << o_q)) begin
						ord_q   <= o_q;
						state_q <= S_AFND;
					end else begin
						o_q <= o_q + 1'b1;
					end
				end
				// Smallest non-empty list at or above the size.
				S_AFND: begin
					if (ord_q > eff_arena_q) begin
						res_status_q <= ST_NOFREE;
						state_q      <= S_DONE;
					end else if (heads_lv[IW]) begin
						idx_q   <= heads_lv[IW-1:0];
						state_q <= S_ASPL;
					end else begin
						ord_q <= ord_q + 1'b1;
					end
				end
				S_ASPL: begin
					u_idx_q <= idx_q;
					state_q <= S_UHD0;
					if (ord_q > o_q) begin
						u_lv_q <= LW'(eff_arena_q - ord_q);
						ret_q  <= S_ACUT;
					end else begin
						u_lv_q <= LW'(eff_arena_q - o_q);
						ret_q  <= S_AGNT;
					end
				end
				S_ACUT: begin
					ord_q   <= ord_q - 1'b1;
					state_q <= S_AUPP;
				end
				S_AUPP: begin
					up_q    <= idx_q + half_sz[IW-1:0];
					state_q <= S_APSH;
				end
				S_APSH: state_q <= S_ASPL;
				S_AGNT: begin
					res_addr_q <= grant_off[ADDR_W-1:0];
					state_q    <= S_DONE;
				end
				// Free: drop addresses that cannot name a block.
				S_FCHK: begin
					idx_q <= f_idx;
					if ((addr_q < ADDR_W'(HEADER_BYTES)) || ((f_mask[ADDR_W-1:0] & f_off) != '0)
							|| ((ADDR_W + 1)'(f_off) >= ((ADDR_W + 1)'(1) << eff_arena_q)))
						state_q <= S_DONE;
					else
						state_q <= S_FTAG;
				end
				S_FTAG: begin
					ord_q   <= tag_rdata[ORD_W-1:0];
					state_q <= push_en ? S_FBUD : S_DONE;
				end
				S_FBUD: begin
					bud_q   <= idx_q ^ half_sz[IW-1:0];
					state_q <= (ord_q < eff_arena_q) ? S_FCMP : S_DONE;
				end
				S_FCMP: begin
					if (tag_rdata != {1'b1, ord_q}) begin
						state_q <= S_DONE;
					end else begin
						u_idx_q <= idx_q;
						u_lv_q  <= LW'(eff_arena_q - ord_q);
						ret_q   <= S_FUL2;
						state_q <= S_UHD0;
					end
				end
				S_FUL2: begin
					u_idx_q <= bud_q;
					ret_q   <= S_FMRG;
					state_q <= S_UHD0;
				end
				S_FMRG: begin
					idx_q   <= merge_idx;
					ord_q   <= ord_q + 1'b1;
					state_q <= S_FBUD;
				end
				// List unlink subroutine.
				S_UHD0: begin
					u_cur_q   <= heads_q[u_lv_q];
					u_steps_q <= '0;
					state_q   <= (heads_q[u_lv_q] == {1'b1, u_idx_q}) ? S_UHED : S_UWLK;
				end
				S_UHED: state_q <= ret_q;
				S_UWLK: begin
					if ((u_steps_q < (IW + 1)'(NBLK)) && u_cur_q[IW]) state_q <= S_UDAT;
					else state_q <= ret_q;
				end
				S_UDAT: begin
					if (link_rdata == {1'b1, u_idx_q}) begin
						state_q <= S_UFIX;
					end else begin
						u_cur_q   <= link_rdata;
						u_steps_q <= u_steps_q + 1'b1;
						state_q   <= S_UWLK;
					end
				end
				S_UFIX: state_q <= ret_q;
				S_DONE: if (!m_valid_q || m_tready) begin
					m_valid_q <= 1'b1;
					m_data_q  <= {2'b00, res_status_q, res_addr_q};
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	bba_store #(
		.IW(IW)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.arena_ord (cfg_acc ? eff_arena_f(new_min, new_arena, MAX_LEVELS) : eff_arena_q),
		.busy      (busy),
		.tag_raddr (tag_raddr),
		.tag_rdata (tag_rdata),
		.tag_waddr (tag_waddr),
		.tag_wdata (tag_wdata),
		.link_raddr(link_raddr),
		.link_rdata(link_rdata),
		.link_waddr(link_waddr),
		.link_wdata(link_wdata)
	);

	// An error result never carries an offset.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[21:20] != ST_OK)) |-> (m_tdata[19:0] == '0))
		else $error("error result with non-zero offset");

	// Status is always one of the three defined codes.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[21:20] != 2'd3))
		else $error("undefined status code");

	// A reinitialisation starts the clearing pass and blocks requests.
	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_acc |=> !s_tready)
		else $error("request accepted during clearing pass");

	// Pushes only ever address a real list level.
	a_push_lv: assert property (@(posedge clk) disable iff (!arst_n)
		push_en |-> ((eff_arena_q - push_ord) <= ORD_W'(MAX_LEVELS)))
		else $error("push beyond the list levels");

endmodule

/* hdl/bba_store.sv */
// ----------------------------------------------------------------------------
// bba_store: block tag and free list link memories
// Holds one tag and one link per minimum block, with a clearing sweep of
// the tags after reset and after each reinitialisation.
// ----------------------------------------------------------------------------
module bba_store import bba_pkg::*; #(
	parameter int IW = MAX_LEVELS_D
) (
	input  logic             clk,
	input  logic             arst_n,
	input  store_ctl_t       ctl,
	input  logic [ORD_W-1:0] arena_ord,
	output logic             busy,
	input  logic [IW-1:0]    tag_raddr,
	output logic [TAG_W-1:0] tag_rdata,
	input  logic [IW-1:0]    tag_waddr,
	input  logic [TAG_W-1:0] tag_wdata,
	input  logic [IW-1:0]    link_raddr,
	output logic [IW:0]      link_rdata,
	input  logic [IW-1:0]    link_waddr,
	input  logic [IW:0]      link_wdata
);

	localparam int NBLK = 1 << IW;

	logic [TAG_W-1:0] tag_mem [NBLK];
	logic [IW:0]      link_mem [NBLK];
	logic [IW-1:0]    sweep_q;
	logic             sweeping_q;
	logic             t_we;
	logic [IW-1:0]    t_addr;
	logic [TAG_W-1:0] t_data;

	// Sweep counter: every tag becomes free, block zero takes the arena order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweeping_q <= 1'b1;
			sweep_q    <= '0;
		end else if (ctl.clear) begin
			sweeping_q <= 1'b1;
			sweep_q    <= '0;
		end else if (sweeping_q) begin
			sweep_q <= sweep_q + 1'b1;
			if (sweep_q == IW'(NBLK - 1)) sweeping_q <= 1'b0;
		end
	end

	assign busy = sweeping_q;

	// The sweep owns the tag write port while it runs.
	always_comb begin
		t_we   = ctl.tag_we;
		t_addr = tag_waddr;
		t_data = tag_wdata;
		if (sweeping_q) begin
			t_we   = 1'b1;
			t_addr = sweep_q;
			t_data = (sweep_q == '0) ? {1'b1, arena_ord} : {1'b1, {ORD_W{1'b0}}};
		end
	end

	// Tag memory with registered read.
	always_ff @(posedge clk) begin
		if (t_we) tag_mem[t_addr] <= t_data;
		tag_rdata <= tag_mem[tag_raddr];
	end

	// Link memory with registered read.
	always_ff @(posedge clk) begin
		if (ctl.link_we) link_mem[link_waddr] <= link_wdata;
		link_rdata <= link_mem[link_raddr];
	end

endmodule
